// ===== sv/vge_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register map and constants for the voice-gated expander gain block.
// No dependencies; every other file refers to this package by scoped names.
package vge_pkg;

    // Register map indexes (byte address = 4 * index)
    localparam logic [2:0] REG_EXPANDER_ENABLE = 3'd0;
    localparam logic [2:0] REG_DENOISE_ENABLE  = 3'd1;
    localparam logic [2:0] REG_REDUCTION_DB    = 3'd2;
    localparam logic [2:0] REG_OPEN_THRESHOLD  = 3'd3;
    localparam logic [2:0] REG_HOLD_TIME_MS    = 3'd4;
    localparam logic [2:0] REG_ATTACK_TIME_MS  = 3'd5;
    localparam logic [2:0] REG_RELEASE_TIME_MS = 3'd6;

    // Reduction ceiling, 96 dB in Q7.8
    localparam logic [14:0] RED_MAX       = 15'd24576;
    // Hysteresis gap, 0.1 in Q12
    localparam logic [12:0] CLOSE_GAP     = 13'd410;
    localparam logic [12:0] THR_RESET     = 13'd2048;
    // log2(10)/20 in Q16
    localparam logic [13:0] LOG_K         = 14'd10885;
    localparam logic [14:0] STEP_MAX      = 15'h7FFF;
    localparam int          MANT_W        = 17;

    // 2^-(1/2) .. 2^-(1/256) in Q16
    localparam logic [15:0] POW_TAB [8] = '{
        16'd46341, 16'd55109, 16'd60097, 16'd62757,
        16'd64132, 16'd64830, 16'd65182, 16'd65359
    };

    // Settings handed from the register file to the gain core
    typedef struct packed {
        logic        active;        // expander and denoise on, reduction nonzero
        logic [14:0] red;           // clamped reduction, Q7.8
        logic [12:0] open_thr;
        logic [13:0] hold_time;
        logic [14:0] attack_step;
        logic [14:0] release_step;
    } vge_cfg_t;

    // Mantissa for one 8-bit fraction of the base-2 exponent, each product rounded
    function automatic logic [MANT_W-1:0] mant_of(input logic [7:0] fr);
        logic [MANT_W-1:0] m;
        logic [33:0]       prod;
        m = MANT_W'(65536);
        for (int j = 0; j < 8; j++) begin
            if (fr[7-j]) begin
                prod = 34'(m) * 34'(POW_TAB[j]) + 34'd32768;
                m    = MANT_W'(prod >> 16);
            end
        end
        return m;
    endfunction

    // Full 256-entry mantissa table, built at elaboration
    function automatic logic [256*MANT_W-1:0] build_mant_rom();
        logic [256*MANT_W-1:0] rom;
        rom = '0;
        for (int i = 0; i < 256; i++) begin
            rom[i*MANT_W +: MANT_W] = mant_of(8'(i));
        end
        return rom;
    endfunction

    localparam logic [256*MANT_W-1:0] MANT_ROM = build_mant_rom();

endpackage

// ===== sv/vge_step_div.sv =====
`timescale 1ns / 1ps
// Slew step calculator: step = round(reduction * FRAME_PERIOD / time) by restoring division.
// One quotient bit per cycle; uses vge_pkg constants.
module vge_step_div #(
    parameter int FRAME_PERIOD = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [14:0] red_amt,
    input  logic [13:0] dur,
    output logic        busy,
    output logic [14:0] step
);

    localparam int NUM_W = $clog2(24576 * FRAME_PERIOD + 8192 + 1);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [13:0]      rem_reg, rem_next;
    logic [13:0]      dur_reg;
    logic [14:0]      red_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    logic [NUM_W-1:0] num;
    logic [14:0]      trial;
    logic             ge;

    // Rounded numerator: reduction * frame length + half the time
    assign num = NUM_W'(red_amt) * NUM_W'(FRAME_PERIOD) + NUM_W'(dur >> 1);

    // Shift in the next numerator bit and try the subtract
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, dur_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? 14'(trial - {1'b0, dur_reg}) : trial[13:0];
            quo_next  = {quo_reg[NUM_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands are latched once per run
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dur_reg <= dur;
            red_reg <= red_amt;
        end
    end

    // Zero time means an instant swing; a step that rounds to zero moves one LSB
    always_comb begin
        if (dur_reg == '0) begin
            step = red_reg;
        end else if (quo_reg == '0) begin
            step = 15'd1;
        end else if (quo_reg > NUM_W'(vge_pkg::STEP_MAX)) begin
            step = vge_pkg::STEP_MAX;
        end else begin
            step = quo_reg[14:0];
        end
    end

    assign busy = busy_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider not busy after start");
    a_idle_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (!busy_reg && !start) |=> !busy_reg)
        else $error("divider went busy without start");

endmodule

// ===== sv/vge_db2lin.sv =====
`timescale 1ns / 1ps
// Attenuation (Q7.8 dB) to Q1.15 linear gain: base-2 exponent, mantissa table, shift.
// Uses the mantissa table from vge_pkg.
module vge_db2lin (
    input  logic [14:0] atten,
    output logic [15:0] lin
);

    logic [28:0]               e;
    logic [3:0]                n;
    logic [7:0]                fr;
    logic [vge_pkg::MANT_W-1:0] m;
    logic [17:0]               sum;
    logic [4:0]                sh;

    // Q24 base-2 exponent; attenuation stays within 96 dB so n fits 4 bits
    assign e   = 29'(atten) * 29'(vge_pkg::LOG_K);
    assign n   = e[27:24];
    assign fr  = e[23:16];
    assign m   = vge_pkg::MANT_ROM[fr*vge_pkg::MANT_W +: vge_pkg::MANT_W];
    // Round half up while shifting down by n + 1
    assign sum = 18'(m) + (18'd1 << n);
    assign sh  = {1'b0, n} + 5'd1;
    assign lin = 16'(sum >> sh);

endmodule

// ===== sv/vge_gain_core.sv =====
`timescale 1ns / 1ps
// Gate, hold and slew state plus the result register of the expander gain.
// Depends on vge_pkg (settings struct) and vge_db2lin.
module vge_gain_core #(
    parameter int FRAME_PERIOD = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  vge_pkg::vge_cfg_t cfg,
    input  logic              step_ready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [12:0]       s_prob,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_lin,
    output logic [15:0]       m_level,
    output logic              m_open
);

    localparam logic [13:0] FRAME_STEP = 14'(FRAME_PERIOD);

    logic [14:0] atten_reg, atten_next;
    logic [13:0] hold_reg, hold_next;
    logic        open_reg, open_next;
    logic        valid_reg, valid_next;
    logic [15:0] lin_reg;
    logic [15:0] level_reg;
    logic        is_open_reg;

    logic        accept;
    logic [12:0] close_thr;
    logic        held;
    logic [14:0] target;
    logic        attack;
    logic [14:0] delta;
    logic [14:0] diff;
    logic [15:0] lin_calc;

    assign s_ready = step_ready && (!valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign close_thr = (cfg.open_thr > vge_pkg::CLOSE_GAP) ?
                       cfg.open_thr - vge_pkg::CLOSE_GAP : '0;

    // Gate with hysteresis, hold countdown, then slew toward the target; bypass forces open, zero attenuation
    always_comb begin
        open_next  = open_reg;
        hold_next  = hold_reg;
        atten_next = atten_reg;
        held       = 1'b0;
        target     = '0;
        attack     = 1'b0;
        delta      = '0;
        diff       = '0;
        if (!cfg.active) begin
            open_next  = 1'b1;
            hold_next  = '0;
            atten_next = '0;
        end else begin
            if (s_prob >= cfg.open_thr) begin
                open_next = 1'b1;
                hold_next = cfg.hold_time;
            end else if (s_prob <= close_thr && open_reg) begin
                open_next = 1'b0;
                hold_next = cfg.hold_time;
            end
            held = !open_next && (hold_next != '0);
            if (held) begin
                hold_next = (hold_next > FRAME_STEP) ? hold_next - FRAME_STEP : '0;
            end
            target = (open_next || held) ? '0 : cfg.red;
            attack = target < atten_reg;
            delta  = attack ? cfg.attack_step : cfg.release_step;
            diff   = attack ? atten_reg - target : target - atten_reg;
            if (diff > delta) begin
                atten_next = attack ? atten_reg - delta : atten_reg + delta;
            end else begin
                atten_next = target;
            end
        end
    end

    vge_db2lin u_db2lin (
        .atten (atten_next),
        .lin   (lin_calc)
    );

    // Hold the result until taken; a new beat may replace it in the same cycle
    assign valid_next = accept ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atten_reg <= '0;
            hold_reg  <= '0;
            open_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                atten_reg <= atten_next;
                hold_reg  <= hold_next;
                open_reg  <= open_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            lin_reg     <= lin_calc;
            level_reg   <= 16'(-{1'b0, atten_next});
            is_open_reg <= open_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_lin   = lin_reg;
    assign m_level = level_reg;
    assign m_open  = is_open_reg;

    a_bypass_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg.active) |=> (atten_reg == '0 && open_reg && m_lin == 16'd32768))
        else $error("bypass beat did not return unity gain");
    a_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> lin_reg <= 16'd32768)
        else $error("linear gain above unity");
    a_level_match: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> level_reg == 16'(-{1'b0, atten_reg}))
        else $error("dB level out of step with state");

endmodule

// ===== sv/voice_gated_expander_gain_top.sv =====
`timescale 1ns / 1ps
// Top level of the voice-gated expander gain: register file, step dividers, gain core.
// Depends on vge_pkg, vge_step_div, vge_db2lin and vge_gain_core.
//
// One voice-probability beat per audio frame gives one gain beat. The block accepts a
// beat every cycle while the step sizes are ready and the result side is not stalled,
// and returns its result in the next cycle through the output register, so it sustains
// one frame per clock under those conditions. After reset and after every register write,
// the attack and release step sizes are recomputed by two restoring dividers, one quotient
// bit per cycle; s_tready stays low for that run.
module voice_gated_expander_gain_top #(
    parameter int FRAME_PERIOD = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [12:0] voice_probability, [15:13] zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] linear_gain, [31:16] level_db
    output logic [0:0]  m_tuser    // [0] is_open
);

    logic        exp_en_reg;
    logic        dn_en_reg;
    logic [14:0] red_reg;
    logic [12:0] thr_reg;
    logic [13:0] hold_reg;
    logic [13:0] attack_reg;
    logic [13:0] release_reg;
    logic        start_reg;

    logic        cfg_wr;
    logic [2:0]  reg_idx;
    logic [14:0] red_clamped;
    logic        atk_busy, rel_busy;
    logic [14:0] atk_step, rel_step;
    logic        step_ready;
    logic [15:0] lin;
    logic [15:0] level;
    logic        is_open;

    vge_pkg::vge_cfg_t cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_en_reg  <= 1'b0;
            dn_en_reg   <= 1'b0;
            red_reg     <= '0;
            thr_reg     <= vge_pkg::THR_RESET;
            hold_reg    <= '0;
            attack_reg  <= '0;
            release_reg <= '0;
            start_reg   <= 1'b1;
        end else begin
            start_reg <= cfg_wr;
            if (cfg_wr) begin
                case (reg_idx)
                    vge_pkg::REG_EXPANDER_ENABLE: exp_en_reg  <= pwdata[0];
                    vge_pkg::REG_DENOISE_ENABLE:  dn_en_reg   <= pwdata[0];
                    vge_pkg::REG_REDUCTION_DB:    red_reg     <= pwdata[14:0];
                    vge_pkg::REG_OPEN_THRESHOLD:  thr_reg     <= pwdata[12:0];
                    vge_pkg::REG_HOLD_TIME_MS:    hold_reg    <= pwdata[13:0];
                    vge_pkg::REG_ATTACK_TIME_MS:  attack_reg  <= pwdata[13:0];
                    vge_pkg::REG_RELEASE_TIME_MS: release_reg <= pwdata[13:0];
                    default: ;
                endcase
            end
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            vge_pkg::REG_EXPANDER_ENABLE: prdata = 32'(exp_en_reg);
            vge_pkg::REG_DENOISE_ENABLE:  prdata = 32'(dn_en_reg);
            vge_pkg::REG_REDUCTION_DB:    prdata = 32'(red_reg);
            vge_pkg::REG_OPEN_THRESHOLD:  prdata = 32'(thr_reg);
            vge_pkg::REG_HOLD_TIME_MS:    prdata = 32'(hold_reg);
            vge_pkg::REG_ATTACK_TIME_MS:  prdata = 32'(attack_reg);
            vge_pkg::REG_RELEASE_TIME_MS: prdata = 32'(release_reg);
            default:                      prdata = '0;
        endcase
    end

    // Reductions above 96 dB act as 96 dB
    assign red_clamped = (red_reg > vge_pkg::RED_MAX) ? vge_pkg::RED_MAX : red_reg;

    vge_step_div #(.FRAME_PERIOD(FRAME_PERIOD)) u_attack_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .red_amt (red_clamped),
        .dur     (attack_reg),
        .busy    (atk_busy),
        .step    (atk_step)
    );

    vge_step_div #(.FRAME_PERIOD(FRAME_PERIOD)) u_release_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .red_amt (red_clamped),
        .dur     (release_reg),
        .busy    (rel_busy),
        .step    (rel_step)
    );

    assign step_ready = !start_reg && !atk_busy && !rel_busy;

    assign cfg.active       = exp_en_reg && dn_en_reg && (red_clamped != '0);
    assign cfg.red          = red_clamped;
    assign cfg.open_thr     = thr_reg;
    assign cfg.hold_time    = hold_reg;
    assign cfg.attack_step  = atk_step;
    assign cfg.release_step = rel_step;

    vge_gain_core #(.FRAME_PERIOD(FRAME_PERIOD)) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step_ready (step_ready),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_prob     (s_tdata[12:0]),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_lin      (lin),
        .m_level    (level),
        .m_open     (is_open)
    );

    assign m_tdata = {level, lin};
    assign m_tuser = is_open;

    a_no_beat_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (start_reg || atk_busy || rel_busy) |-> !s_tready)
        else $error("input beat taken while step sizes are stale");

endmodule

// ===== test/tb_voice_gated_expander_gain_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for voice_gated_expander_gain_top: APB register setup, probability
// beats in, gain beats checked against an in-bench gain predictor. Depends on vge_pkg and the RTL.
module tb_voice_gated_expander_gain_top;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRESSURE_CYCLES = 300;
    localparam int PHASE_COUNT = 16;
    localparam int PHASE_BEATS = 38;

    // One expected gain beat
    typedef struct packed {
        logic [15:0] lin;
        logic [15:0] db;
        logic        is_open;
    } gain_beat_t;

    // Gain predictor and queue of expected gain beats
    class gain_scoreboard;
        localparam int unsigned FRAME_LEN = 10;
        localparam int unsigned ATTEN_CEIL = 24576;
        localparam int unsigned HYST_GAP = 410;
        localparam int unsigned LOG2_10_OVER_20 = 10885;

        bit                    exp_en;
        bit                    dn_en;
        logic [14:0]           red_cfg;
        logic [12:0]           thr;
        logic [13:0]           hold_ms;
        logic [13:0]           atk_time;
        logic [13:0]           rel_time;
        int unsigned           atten;
        int unsigned           hold_left;
        bit                    gate_open;
        gain_beat_t            expected_q[$];
        int                    errors;

        function new();
            exp_en     = 0;
            dn_en      = 0;
            red_cfg    = '0;
            thr        = 13'd2048;
            hold_ms    = '0;
            atk_time   = '0;
            rel_time   = '0;
            atten      = 0;
            hold_left  = 0;
            gate_open  = 1;
            errors     = 0;
        endfunction

        function void write_reg(logic [2:0] idx, int unsigned v);
            case (idx)
                vge_pkg::REG_EXPANDER_ENABLE: exp_en = v[0];
                vge_pkg::REG_DENOISE_ENABLE:  dn_en = v[0];
                vge_pkg::REG_REDUCTION_DB:    red_cfg = v[14:0];
                vge_pkg::REG_OPEN_THRESHOLD:  thr = v[12:0];
                vge_pkg::REG_HOLD_TIME_MS:    hold_ms = v[13:0];
                vge_pkg::REG_ATTACK_TIME_MS:  atk_time = v[13:0];
                vge_pkg::REG_RELEASE_TIME_MS: rel_time = v[13:0];
                default: ;
            endcase
        endfunction

        // Q16 factor 2^-(1/2^(j+1))
        function longint unsigned frac_factor(int j);
            case (j)
                0: return 46341;
                1: return 55109;
                2: return 60097;
                3: return 62757;
                4: return 64132;
                5: return 64830;
                6: return 65182;
                default: return 65359;
            endcase
        endfunction

        // Attenuation in Q7.8 dB to Q1.15 amplitude
        function logic [15:0] atten_to_gain(int unsigned att);
            longint unsigned e;
            longint unsigned m;
            int unsigned     n;
            int unsigned     fr;
            e  = longint'(att) * LOG2_10_OVER_20;
            n  = int'(e >> 24);
            fr = int'((e >> 16) & 8'hFF);
            m  = 65536;
            for (int j = 0; j < 8; j++) begin
                if ((fr >> (7 - j)) & 1)
                    m = (m * frac_factor(j) + 32768) >> 16;
            end
            if (n > 15)
                n = 15;
            return 16'((m + (longint'(1) << n)) >> (n + 1));
        endfunction

        // Advance the gate and gain state by one frame, queue the expected beat
        function void note_input(logic [12:0] prob);
            int unsigned red;
            int unsigned close_thr;
            int unsigned target;
            int unsigned dur;
            int unsigned delta;
            bit          holding;
            gain_beat_t  g;
            red = (red_cfg > ATTEN_CEIL) ? ATTEN_CEIL : red_cfg;
            if (!exp_en || !dn_en || red == 0) begin
                atten     = 0;
                hold_left = 0;
                gate_open = 1;
                g.lin     = 16'd32768;
                g.db      = 16'd0;
                g.is_open = 1'b1;
                expected_q.push_back(g);
                return;
            end
            close_thr = (thr > HYST_GAP) ? thr - HYST_GAP : 0;
            if (prob >= thr) begin
                gate_open = 1;
                hold_left = hold_ms;
            end else if (prob <= close_thr && gate_open) begin
                gate_open = 0;
                hold_left = hold_ms;
            end
            holding = !gate_open && hold_left > 0;
            if (holding)
                hold_left = (hold_left > FRAME_LEN) ? hold_left - FRAME_LEN : 0;
            target = (gate_open || holding) ? 0 : red;
            dur = (target < atten) ? atk_time : rel_time;
            if (dur == 0) begin
                delta = red;
            end else begin
                delta = (red * FRAME_LEN + dur / 2) / dur;
                if (delta == 0)
                    delta = 1;
            end
            if (target < atten)
                atten = (atten - target > delta) ? atten - delta : target;
            else
                atten = (target - atten > delta) ? atten + delta : target;
            g.lin     = atten_to_gain(atten);
            g.db      = 16'(0 - atten);
            g.is_open = gate_open;
            expected_q.push_back(g);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Compare one gain beat against the oldest expectation
        function void check_result(logic [31:0] data, logic user);
            gain_beat_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected gain beat lin=%0d db=%0d open=%0d",
                         $time, data[15:0], $signed(data[31:16]), user);
                return;
            end
            want = expected_q.pop_front();
            if (data[15:0] !== want.lin) begin
                errors++;
                $display("%0t: linear_gain expected %0d actual %0d",
                         $time, want.lin, data[15:0]);
            end
            if (data[31:16] !== want.db) begin
                errors++;
                $display("%0t: level_db expected %0d actual %0d",
                         $time, $signed(want.db), $signed(data[31:16]));
            end
            if (user !== want.is_open) begin
                errors++;
                $display("%0t: is_open expected %0d actual %0d",
                         $time, want.is_open, user);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    gain_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit rx_pressure = 1'b0;
    bit pressure_done = 1'b0;
    int pressure_count = 0;
    int cycle_count = 0;

    voice_gated_expander_gain_top uut (.*);

    // Clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("voice_gated_expander_gain_top verification failed");
            $finish;
        end
    end

    // Drive result-side backpressure; one long hold-off when asked
    always @(negedge aclk) begin
        if (rx_pressure && !pressure_done) begin
            m_tready <= 1'b0;
            pressure_count <= pressure_count + 1;
            if (pressure_count >= PRESSURE_CYCLES)
                pressure_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Check every accepted gain beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
    end

    // Offer one probability beat, hold it until accepted
    task automatic send_beat(logic [12:0] prob);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, prob};
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_input(prob);
    endtask

    // Wait until every expected gain beat is back and the block is idle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic reg_write(logic [2:0] idx, int unsigned value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    function automatic int unsigned pick_time();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 16383;
            2: return 10000;
            3, 4: return $urandom_range(1, 200);
            default: return $urandom_range(1, 16383);
        endcase
    endfunction

    // New random setting; registers rewritten all at once or each by chance
    task automatic random_config(bit write_all);
        int unsigned v;
        if (write_all || $urandom_range(1)) begin
            reg_write(vge_pkg::REG_EXPANDER_ENABLE, ($urandom_range(9) != 0));
        end
        if (write_all || $urandom_range(1)) begin
            reg_write(vge_pkg::REG_DENOISE_ENABLE, ($urandom_range(9) != 0));
        end
        if (write_all || $urandom_range(1)) begin
            case ($urandom_range(0, 6))
                0: v = 0;
                1: v = 24576;
                2: v = 32767;
                3: v = $urandom_range(24577, 32767);
                4: v = $urandom_range(1, 600);
                default: v = $urandom_range(1, 24576);
            endcase
            reg_write(vge_pkg::REG_REDUCTION_DB, v);
        end
        if (write_all || $urandom_range(1)) begin
            case ($urandom_range(0, 5))
                0: v = 0;
                1: v = 4096;
                2: v = 8191;
                3: v = $urandom_range(0, 8191);
                default: v = $urandom_range(410, 4096);
            endcase
            reg_write(vge_pkg::REG_OPEN_THRESHOLD, v);
        end
        if (write_all || $urandom_range(1)) begin
            case ($urandom_range(0, 4))
                0: v = 0;
                1: v = 16383;
                2: v = $urandom_range(0, 16383);
                default: v = $urandom_range(0, 60);
            endcase
            reg_write(vge_pkg::REG_HOLD_TIME_MS, v);
        end
        if (write_all || $urandom_range(1))
            reg_write(vge_pkg::REG_ATTACK_TIME_MS, pick_time());
        if (write_all || $urandom_range(1))
            reg_write(vge_pkg::REG_RELEASE_TIME_MS, pick_time());
    endtask

    // Probability aimed at opening, closing, the hysteresis band, or anywhere
    function automatic logic [12:0] random_prob(int kind);
        int unsigned t;
        int unsigned c;
        t = sb.thr;
        c = (t > 410) ? t - 410 : 0;
        case (kind)
            0: return (t <= 4096) ? 13'($urandom_range(t, 4096)) : 13'($urandom_range(t, 8191));
            1: return 13'($urandom_range(0, c));
            2: return (t > c + 1) ? 13'($urandom_range(c + 1, t - 1))
                                  : 13'($urandom_range(0, 4096));
            default: return 13'($urandom_range(0, 8191));
        endcase
    endfunction

    initial begin
        int sent;
        int run_len;
        int r;
        int kind;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Bypass out of reset, both extremes of the probability
        send_beat(13'd0);
        send_beat(13'd8191);
        drain();
        reg_write(vge_pkg::REG_EXPANDER_ENABLE, 1);
        send_beat(13'd4096);
        drain();

        // Full reduction, instant swings: open at threshold, close at threshold - 0.1
        reg_write(vge_pkg::REG_DENOISE_ENABLE, 1);
        reg_write(vge_pkg::REG_REDUCTION_DB, 24576);
        send_beat(13'd2048);
        send_beat(13'd1639);
        send_beat(13'd1638);
        send_beat(13'd0);
        send_beat(13'd2047);
        send_beat(13'd2048);
        drain();

        // Hold countdown that saturates, then paced release and attack
        reg_write(vge_pkg::REG_HOLD_TIME_MS, 15);
        reg_write(vge_pkg::REG_RELEASE_TIME_MS, 100);
        reg_write(vge_pkg::REG_ATTACK_TIME_MS, 50);
        repeat (5) send_beat(13'd0);
        send_beat(13'd4096);
        drain();

        // Reduction above range, threshold above 1.0
        reg_write(vge_pkg::REG_REDUCTION_DB, 32767);
        reg_write(vge_pkg::REG_OPEN_THRESHOLD, 8191);
        reg_write(vge_pkg::REG_RELEASE_TIME_MS, 10000);
        reg_write(vge_pkg::REG_ATTACK_TIME_MS, 16383);
        send_beat(13'd8191);
        send_beat(13'd4096);
        send_beat(13'd0);
        send_beat(13'd0);
        drain();

        // Tiny step raised to one, closing threshold floored at zero
        reg_write(vge_pkg::REG_REDUCTION_DB, 1);
        reg_write(vge_pkg::REG_OPEN_THRESHOLD, 300);
        reg_write(vge_pkg::REG_RELEASE_TIME_MS, 16383);
        send_beat(13'd0);
        send_beat(13'd0);
        send_beat(13'd299);
        send_beat(13'd300);
        drain();
        reg_write(vge_pkg::REG_OPEN_THRESHOLD, 0);
        send_beat(13'd0);
        drain();
        reg_write(vge_pkg::REG_REDUCTION_DB, 0);
        send_beat(13'd0);
        drain();

        // Random phases: new setting, new idle pattern, bursts around the thresholds
        for (int p = 0; p < PHASE_COUNT; p++) begin
            random_config(p == 0);
            case (p % 5)
                1: begin tx_idle_pct = 52; rx_stall_pct = 0; end
                2: begin tx_idle_pct = 0; rx_stall_pct = 52; end
                3: begin tx_idle_pct = 24; rx_stall_pct = 24; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            if (p == 4)
                rx_pressure = 1'b1;
            sent = 0;
            while (sent < PHASE_BEATS) begin
                run_len = $urandom_range(1, 12);
                r = $urandom_range(0, 9);
                kind = (r < 4) ? 0 : (r < 8) ? 1 : (r == 8) ? 2 : 3;
                for (int i = 0; i < run_len; i++)
                    send_beat(random_prob(kind));
                sent += run_len;
            end
            drain();
        end

        repeat (4) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("voice_gated_expander_gain_top verification clean");
        end else begin
            $display("voice_gated_expander_gain_top verification failed");
        end
        $finish;
    end

endmodule

// ===== voice_gated_expander_gain_top.f =====
sv/vge_pkg.sv
sv/vge_step_div.sv
sv/vge_db2lin.sv
sv/vge_gain_core.sv
sv/voice_gated_expander_gain_top.sv
test/tb_voice_gated_expander_gain_top.sv
